// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the tokenizer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/fdt_pkg.sv
// ---------------------------------------------------------------------------
// fdt_pkg
// Types and constants shared by the format directive tokenizer modules.
// ---------------------------------------------------------------------------
package fdt_pkg;

  // Token kinds as they appear on the kind port.
  typedef enum logic [3:0] {
    K_INVALID = 4'd0,
    K_LITERAL = 4'd1,
    K_PERCENT = 4'd2,
    K_CHAR    = 4'd3,
    K_STR     = 4'd4,
    K_UINT    = 4'd5,
    K_SINT    = 4'd6,
    K_HEX     = 4'd7,
    K_END     = 4'd8
  } kind_t;

  // Byte classes produced by the front end.
  typedef enum logic [2:0] {
    CLS_TERM    = 3'd0,
    CLS_PERCENT = 3'd1,
    CLS_ZERO    = 3'd2,
    CLS_MINUS   = 3'd3,
    CLS_DOT     = 3'd4,
    CLS_DIGIT   = 3'd5,
    CLS_OTHER   = 3'd6
  } class_t;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    class_t     cls;
    logic [3:0] digit;
    kind_t      conv;
    logic       upper;
  } entry_t;

  // One output token.
  typedef struct packed {
    kind_t       kind;
    logic        zero_fill;
    logic        align_left;
    logic        uppercase;
    logic [15:0] field_width;
    logic        has_precision;
    logic [15:0] precision_value;
    logic [15:0] run_offset;
    logic [15:0] run_length;
    logic [15:0] resume_position;
    logic        last;
  } token_t;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_TERM    = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_I = 8'h69;
  localparam logic [7:0] CH_LOWER_S = 8'h73;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

endpackage

// File: src/fdt_front.sv
// ---------------------------------------------------------------------------
// fdt_front
// Input side: accepts format bytes and classifies them for the parser.
// ---------------------------------------------------------------------------
module fdt_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     ch,
  input  logic           full,
  output logic           push,
  output fdt_pkg::entry_t entry
);
  import fdt_pkg::*;

  always_comb begin
    entry.digit = ch[3:0];
    entry.upper = (ch == CH_UPPER_X);
    priority if (ch == CH_TERM) begin
      entry.cls = CLS_TERM;
    end else if (ch == CH_PERCENT) begin
      entry.cls = CLS_PERCENT;
    end else if (ch == CH_ZERO) begin
      entry.cls = CLS_ZERO;
    end else if (ch == CH_MINUS) begin
      entry.cls = CLS_MINUS;
    end else if (ch == CH_DOT) begin
      entry.cls = CLS_DOT;
    end else if (ch > CH_ZERO && ch <= CH_NINE) begin
      entry.cls = CLS_DIGIT;
    end else begin
      entry.cls = CLS_OTHER;
    end

    // Conversion meaning of the byte, used when it closes a directive.
    priority if (ch == CH_PERCENT) begin
      entry.conv = K_PERCENT;
    end else if (ch == CH_LOWER_C) begin
      entry.conv = K_CHAR;
    end else if (ch == CH_LOWER_S) begin
      entry.conv = K_STR;
    end else if (ch == CH_LOWER_U) begin
      entry.conv = K_UINT;
    end else if (ch == CH_LOWER_D || ch == CH_LOWER_I) begin
      entry.conv = K_SINT;
    end else if (ch == CH_LOWER_X || ch == CH_UPPER_X) begin
      entry.conv = K_HEX;
    end else begin
      entry.conv = K_INVALID;
    end
  end

  assign in_ready = !full;
  assign push     = in_valid && !full;

endmodule

// File: src/fdt_fifo.sv
// ---------------------------------------------------------------------------
// fdt_fifo
// Short register queue between the classifier and the parser.
// ---------------------------------------------------------------------------
module fdt_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: src/fdt_back.sv
// ---------------------------------------------------------------------------
// fdt_back
// Parser state machine and output token register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fdt_back #(
  parameter int VALUE_BITS    = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  fdt_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output fdt_pkg::token_t tok
);
  import fdt_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LITERAL = 3'd1,
    PH_FLAGS   = 3'd2,
    PH_WIDTH   = 3'd3,
    PH_PREC    = 3'd4
  } phase_t;

  phase_t                   phase, phase_next;
  logic [POSITION_BITS-1:0] position, position_next;
  logic [POSITION_BITS-1:0] literal_origin, literal_origin_next;
  logic [2:0]               flag_bits, flag_bits_next;
  logic [VALUE_BITS-1:0]    width_accum, width_accum_next;
  logic [VALUE_BITS-1:0]    precision_accum, precision_accum_next;
  logic                     second, second_next;

  logic [POSITION_BITS-1:0] pos_inc;
  logic [POSITION_BITS-1:0] run_len;
  logic [VALUE_BITS-1:0]    acc_sel;
  logic [VALUE_BITS+3:0]    acc_ext;
  logic [VALUE_BITS+3:0]    prod;
  logic                     ovf;
  logic                     go_idle;
  logic                     lead_valid;
  logic                     has_end;
  logic                     pair;
  logic                     out_free;
  logic                     load;
  logic                     lead_kind_ok;
  logic                     end_clean;
  token_t                   lead, end_tok, tok_next;

  assign pos_inc = (position == '1) ? position : position + POSITION_BITS'(1);
  assign run_len = position - literal_origin;
  assign acc_sel = (phase == PH_PREC) ? precision_accum : width_accum;
  assign acc_ext = {4'b0000, acc_sel};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + {{VALUE_BITS{1'b0}}, head.digit};
  assign ovf     = |prod[VALUE_BITS+3:VALUE_BITS];

  always_comb begin
    phase_next           = phase;
    position_next        = position;
    literal_origin_next  = literal_origin;
    flag_bits_next       = flag_bits;
    width_accum_next     = width_accum;
    precision_accum_next = precision_accum;
    go_idle              = 1'b0;
    lead_valid           = 1'b0;
    has_end              = 1'b0;

    // Directive token template; branches override kind, case, resume or the run fields.
    lead.kind            = K_INVALID;
    lead.zero_fill       = flag_bits[0];
    lead.align_left      = flag_bits[1];
    lead.uppercase       = 1'b0;
    lead.field_width     = 16'(width_accum);
    lead.has_precision   = flag_bits[2];
    lead.precision_value = 16'(precision_accum);
    lead.run_offset      = '0;
    lead.run_length      = '0;
    lead.resume_position = 16'(position);
    lead.last            = 1'b1;

    unique case (phase)
      PH_LITERAL: begin
        if (head.cls != CLS_TERM && head.cls != CLS_PERCENT) begin
          position_next = pos_inc;
        end else begin
          lead_valid           = 1'b1;
          lead.kind            = K_LITERAL;
          lead.zero_fill       = 1'b0;
          lead.align_left      = 1'b0;
          lead.field_width     = '0;
          lead.has_precision   = 1'b0;
          lead.precision_value = '0;
          lead.run_offset      = 16'(literal_origin);
          lead.run_length      = 16'(run_len);
          go_idle              = 1'b1;
        end
      end
      PH_FLAGS, PH_WIDTH, PH_PREC: begin
        priority if (head.cls == CLS_TERM) begin
          lead_valid = 1'b1;
          go_idle    = 1'b1;
        end else if (phase == PH_FLAGS && head.cls == CLS_ZERO) begin
          flag_bits_next[0] = 1'b1;
          position_next     = pos_inc;
        end else if (phase == PH_FLAGS && head.cls == CLS_MINUS) begin
          flag_bits_next[1] = 1'b1;
          position_next     = pos_inc;
        end else if (head.cls == CLS_ZERO || head.cls == CLS_DIGIT) begin
          if (phase == PH_FLAGS) begin
            phase_next = PH_WIDTH;
          end
          if (!ovf) begin
            if (phase == PH_PREC) begin
              precision_accum_next = prod[VALUE_BITS-1:0];
            end else begin
              width_accum_next = prod[VALUE_BITS-1:0];
            end
            position_next = pos_inc;
          end else begin
            lead_valid          = 1'b1;
            literal_origin_next = position;
            phase_next          = PH_LITERAL;
            position_next       = pos_inc;
          end
        end else if (head.cls == CLS_DOT && phase != PH_PREC) begin
          flag_bits_next[2] = 1'b1;
          phase_next        = PH_PREC;
          position_next     = pos_inc;
        end else begin
          lead_valid           = 1'b1;
          lead.kind            = head.conv;
          lead.uppercase       = head.upper;
          lead.resume_position = 16'(pos_inc);
          phase_next           = PH_IDLE;
          position_next        = pos_inc;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    if (go_idle) begin
      priority if (head.cls == CLS_TERM) begin
        has_end       = 1'b1;
        position_next = '0;
        phase_next    = PH_IDLE;
      end else if (head.cls == CLS_PERCENT) begin
        flag_bits_next       = '0;
        width_accum_next     = '0;
        precision_accum_next = '0;
        phase_next           = PH_FLAGS;
        position_next        = pos_inc;
      end else begin
        literal_origin_next = position;
        phase_next          = PH_LITERAL;
        position_next       = pos_inc;
      end
    end
  end

  always_comb begin
    end_tok      = '0;
    end_tok.kind = K_END;
    end_tok.last = 1'b1;
  end

  // A pair is a literal or invalid token followed by the end token.
  assign pair     = lead_valid && has_end;
  assign out_free = !out_valid || out_ready;
  assign load     = head_valid && (lead_valid || has_end) && out_free;
  assign pop      = head_valid && (!pair || second) && (out_free || !(lead_valid || has_end));

  always_comb begin
    if (pair && !second) begin
      tok_next      = lead;
      tok_next.last = 1'b0;
    end else if (has_end) begin
      tok_next = end_tok;
    end else begin
      tok_next = lead;
    end

    if (load && pair && !second) begin
      second_next = 1'b1;
    end else if (pop) begin
      second_next = 1'b0;
    end else begin
      second_next = second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      position        <= '0;
      literal_origin  <= '0;
      flag_bits       <= '0;
      width_accum     <= '0;
      precision_accum <= '0;
      second          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        phase           <= phase_next;
        position        <= position_next;
        literal_origin  <= literal_origin_next;
        flag_bits       <= flag_bits_next;
        width_accum     <= width_accum_next;
        precision_accum <= precision_accum_next;
      end
      second <= second_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok <= tok_next;
    end
  end

  assign lead_kind_ok = (tok.kind == K_LITERAL) || (tok.kind == K_INVALID);
  assign end_clean    = (tok.resume_position == '0) && (tok.run_length == '0) && tok.last;

  `ASSERT_IMPLIES(a_second_has_head, clk, rst, second, head_valid, "end token without its byte")
  `ASSERT_IMPLIES(a_first_of_pair, clk, rst, out_valid && !tok.last, lead_kind_ok, "bad first kind")
  `ASSERT_IMPLIES(a_end_clean, clk, rst, out_valid && tok.kind == K_END, end_clean, "stale end token")
  `ASSERT_NEXT(a_pair_then_end, clk, rst, load && pair && !second, second, "pair lost its end")

endmodule

// File: src/format_directive_tokenizer.sv
// ---------------------------------------------------------------------------
// format_directive_tokenizer
// Splits a printf-style format string, one byte per beat, into tokens.
// ---------------------------------------------------------------------------
// The block takes one format byte per clock cycle while the queue has room
// and returns one token per literal run or directive, plus an end token at
// the terminator byte. Most bytes produce no token and only update the parse
// state; a byte that closes a literal or a directive produces one token. A
// terminator that cuts off a literal run or an unfinished directive produces
// two tokens, the literal or invalid token and then the end token, and the
// parser holds that byte until both tokens are loaded, one after the other,
// since the output register takes one token per cycle at most. When nothing
// stalls, the byte is written into the queue and the token it closes is then
// loaded into the output register, where it is valid on the output ports. The
// classifier and the parser are parted by a two-entry queue, so input beats
// keep being accepted while a finished token waits for the consumer, until two
// bytes sit in the queue; the queue and the single output register together
// absorb a stall on either side. No clearing pass is needed after reset: the
// block is ready for its first byte as soon as reset is released.
// ---------------------------------------------------------------------------
module format_directive_tokenizer #(
  parameter int VALUE_BITS    = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic        zero_fill,
  output logic        align_left,
  output logic        uppercase,
  output logic [15:0] field_width,
  output logic        has_precision,
  output logic [15:0] precision_value,
  output logic [15:0] run_offset,
  output logic [15:0] run_length,
  output logic [15:0] resume_position,
  output logic        last
);
  import fdt_pkg::*;

  // Classified bytes flow from the front end into the queue.
  entry_t            push_entry;
  logic              push;
  logic              full;

  // The parser pops one queued byte when it has finished with it.
  logic              head_valid;
  logic [$bits(entry_t)-1:0] head_bits;
  entry_t            head;
  logic              pop;

  // The output token register sits inside the parser.
  token_t            tok;

  fdt_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .full     (full),
    .push     (push),
    .entry    (push_entry)
  );

  fdt_fifo #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .full      (full),
    .pop       (pop),
    .pop_valid (head_valid),
    .pop_data  (head_bits)
  );

  assign head = entry_t'(head_bits);

  fdt_back #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tok        (tok)
  );

  // Each token field goes out on a port of its own.
  assign kind            = tok.kind;
  assign zero_fill       = tok.zero_fill;
  assign align_left      = tok.align_left;
  assign uppercase       = tok.uppercase;
  assign field_width     = tok.field_width;
  assign has_precision   = tok.has_precision;
  assign precision_value = tok.precision_value;
  assign run_offset      = tok.run_offset;
  assign run_length      = tok.run_length;
  assign resume_position = tok.resume_position;
  assign last            = tok.last;

endmodule

// File: bench/format_directive_tokenizer_tb.sv
// ---------------------------------------------------------------------------
// format_directive_tokenizer_tb
// Self-checking bench for the printf-style format string tokenizer.
// ---------------------------------------------------------------------------
// Bytes go in on a valid/ready channel. Tokens come back on a second
// valid/ready channel. A behavioral tokenizer inside the bench tracks the
// parse state for every byte beat the block accepts and queues the tokens it
// should produce. Each token beat is checked field by field against the
// oldest queued token.
// The run has three parts. A short scripted string comes first, covering the
// field extremes, several conversions, an unknown conversion, a directive cut
// off by the terminator, a literal closed by the terminator and a width that
// overflows. Random format strings follow, mostly well formed with random
// flags, widths, precisions and conversions, with some noise bytes mixed in.
// The last part is one longer literal run sent without idling, followed by a
// directive and another literal. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module format_directive_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fdt_pkg::*;

  localparam int RANDOM_BYTES = 1000;
  localparam int LONG_RUN_BYTES = 48;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int MAX_VALUE = 65535;

  // Parse phases of the bench's own tokenizer.
  typedef enum logic [2:0] {
    P_IDLE    = 3'd0,
    P_LITERAL = 3'd1,
    P_FLAGS   = 3'd2,
    P_WIDTH   = 3'd3,
    P_PREC    = 3'd4
  } phase_t;

  // One line of the scripted string. When fixed is set, the token in
  // fixed_tok replaces the computed one for that byte.
  typedef struct {
    logic [7:0] ch;
    bit         fixed;
    token_t     fixed_tok;
  } script_row_t;

  localparam logic [7:0] CONV_BYTES [8] = '{
    CH_PERCENT, CH_LOWER_C, CH_LOWER_S, CH_LOWER_U,
    CH_LOWER_D, CH_LOWER_I, CH_LOWER_X, CH_UPPER_X
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ch = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  kind;
  logic        zero_fill;
  logic        align_left;
  logic        uppercase;
  logic [15:0] field_width;
  logic        has_precision;
  logic [15:0] precision_value;
  logic [15:0] run_offset;
  logic [15:0] run_length;
  logic [15:0] resume_position;
  logic        last;

  format_directive_tokenizer u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .ch              (ch),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .zero_fill       (zero_fill),
    .align_left      (align_left),
    .uppercase       (uppercase),
    .field_width     (field_width),
    .has_precision   (has_precision),
    .precision_value (precision_value),
    .run_offset      (run_offset),
    .run_length      (run_length),
    .resume_position (resume_position),
    .last            (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Parse state of the bench's tokenizer, starting from the reset values.
  phase_t      ph = P_IDLE;
  logic [15:0] pos = '0;
  logic [15:0] lit_origin = '0;
  logic [2:0]  flags = '0;
  logic [15:0] width_acc = '0;
  logic [15:0] prec_acc = '0;

  token_t      expected_tokens [$];
  script_row_t script [$];
  int          mismatches = 0;
  int          sent_bytes = 0;
  int          cycles = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;
  token_t      got_tok;
  token_t      want_tok;

  // The position counter sticks at its top value instead of wrapping.
  function automatic void step_position();
    if (pos != 16'hFFFF) begin
      pos = pos + 16'd1;
    end
  endfunction

  // Directive fields are only filled in for directive and invalid tokens;
  // literal and end tokens carry zeros there.
  function automatic token_t make_token(kind_t k, bit dir, bit upper,
                                        logic [15:0] rs, logic [15:0] rl,
                                        logic [15:0] rp);
    token_t t;
    t = '0;
    t.kind            = k;
    t.zero_fill       = dir & flags[0];
    t.align_left      = dir & flags[1];
    t.uppercase       = upper;
    t.field_width     = dir ? width_acc : 16'd0;
    t.has_precision   = dir & flags[2];
    t.precision_value = dir ? prec_acc : 16'd0;
    t.run_offset      = rs;
    t.run_length      = rl;
    t.resume_position = rp;
    return t;
  endfunction

  function automatic token_t fixed_token(kind_t k, logic [15:0] rs,
                                         logic [15:0] rl, logic [15:0] rp);
    token_t t;
    t = make_token(k, 1'b0, 1'b0, rs, rl, rp);
    t.last = 1'b1;
    return t;
  endfunction

  // Advances the parse state by one byte and returns the tokens it closes,
  // at most two: a literal or an invalid token, then the end token.
  function automatic void tokenize_byte(input logic [7:0] c,
                                        output token_t t0, output token_t t1,
                                        output int n);
    token_t res [2];
    int     cnt;
    bit     done;
    bit     is_digit;
    bit     into_prec;
    int     d;
    int     acc;
    kind_t  k;
    res[0] = '0;
    res[1] = '0;
    cnt = 0;
    done = 1'b0;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = int'(c) - int'(CH_ZERO);

    if (ph == P_LITERAL) begin
      if (c != CH_TERM && c != CH_PERCENT) begin
        step_position();
        done = 1'b1;
      end else begin
        // The run closes here; the byte is then handled as from idle.
        res[cnt] = make_token(K_LITERAL, 1'b0, 1'b0, lit_origin,
                              pos - lit_origin, pos);
        cnt++;
        ph = P_IDLE;
      end
    end else if (ph == P_FLAGS || ph == P_WIDTH || ph == P_PREC) begin
      if (c == CH_TERM) begin
        // Directive cut off: invalid token resuming at the terminator.
        res[cnt] = make_token(K_INVALID, 1'b1, 1'b0, 16'd0, 16'd0, pos);
        cnt++;
        ph = P_IDLE;
      end else if (ph == P_FLAGS && c == CH_ZERO) begin
        flags[0] = 1'b1;
        step_position();
        done = 1'b1;
      end else if (ph == P_FLAGS && c == CH_MINUS) begin
        flags[1] = 1'b1;
        step_position();
        done = 1'b1;
      end else if (is_digit) begin
        into_prec = (ph == P_PREC);
        if (ph == P_FLAGS) begin
          ph = P_WIDTH;
        end
        acc = into_prec ? int'(prec_acc) : int'(width_acc);
        if (acc > (MAX_VALUE - d) / 10) begin
          // Overflow: report the value so far, and the digit opens a
          // new literal run.
          res[cnt] = make_token(K_INVALID, 1'b1, 1'b0, 16'd0, 16'd0, pos);
          cnt++;
          lit_origin = pos;
          ph = P_LITERAL;
        end else if (into_prec) begin
          prec_acc = 16'(acc * 10 + d);
        end else begin
          width_acc = 16'(acc * 10 + d);
        end
        step_position();
        done = 1'b1;
      end else if (c == CH_DOT && ph != P_PREC) begin
        flags[2] = 1'b1;
        ph = P_PREC;
        step_position();
        done = 1'b1;
      end else begin
        case (c)
          CH_PERCENT:             k = K_PERCENT;
          CH_LOWER_C:             k = K_CHAR;
          CH_LOWER_S:             k = K_STR;
          CH_LOWER_U:             k = K_UINT;
          CH_LOWER_D, CH_LOWER_I: k = K_SINT;
          CH_LOWER_X, CH_UPPER_X: k = K_HEX;
          default:                k = K_INVALID;
        endcase
        // The conversion byte is consumed before the resume point is taken.
        step_position();
        res[cnt] = make_token(k, 1'b1, c == CH_UPPER_X, 16'd0, 16'd0, pos);
        cnt++;
        ph = P_IDLE;
        done = 1'b1;
      end
    end else begin
      ph = P_IDLE;
    end

    if (!done) begin
      if (c == CH_TERM) begin
        res[cnt] = make_token(K_END, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
        cnt++;
        pos = '0;
        ph = P_IDLE;
      end else if (c == CH_PERCENT) begin
        flags = '0;
        width_acc = '0;
        prec_acc = '0;
        ph = P_FLAGS;
        step_position();
      end else begin
        lit_origin = pos;
        ph = P_LITERAL;
        step_position();
      end
    end

    if (cnt > 0) begin
      res[cnt - 1].last = 1'b1;
    end
    t0 = res[0];
    t1 = res[1];
    n = cnt;
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Any byte that keeps a literal run going.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    while (b == CH_PERCENT) begin
      b = 8'($urandom_range(1, 255));
    end
    return b;
  endfunction

  function automatic logic [7:0] digit_byte();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic string token_text(token_t t);
    return $sformatf({"kind=%0d zp=%b lj=%b up=%b w=%0d hp=%b p=%0d ",
                      "rs=%0d rl=%0d rp=%0d last=%b"},
                     t.kind, t.zero_fill, t.align_left, t.uppercase,
                     t.field_width, t.has_precision, t.precision_value,
                     t.run_offset, t.run_length, t.resume_position, t.last);
  endfunction

  task automatic add_row(logic [7:0] c, bit fixed = 1'b0, token_t t = '0);
    script_row_t row;
    row.ch = c;
    row.fixed = fixed;
    row.fixed_tok = t;
    script.push_back(row);
  endtask

  // Presents one byte, holds it until the beat is taken, queues the tokens
  // it closes, then maybe idles. Valid is never dropped and raised at the
  // same edge: it only falls here when a gap follows.
  task automatic send_byte(logic [7:0] b, bit fixed = 1'b0, token_t t = '0);
    token_t t0;
    token_t t1;
    int     n;
    int     gap;
    in_valid <= 1'b1;
    ch <= b;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    tokenize_byte(b, t0, t1, n);
    if (fixed && n == 1) begin
      t0 = t;
    end
    if (n > 0) begin
      expected_tokens.push_back(t0);
    end
    if (n > 1) begin
      expected_tokens.push_back(t1);
    end
    sent_bytes++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender off until every queued token has come back. One edge
  // always passes first, so valid never falls and rises in the same step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Random format string material: literal runs, directives with random
  // flags, widths, precisions and conversions, terminators and noise.
  task automatic send_random_piece();
    int r;
    int nd;
    r = $urandom_range(0, 9);
    if (r <= 2) begin
      repeat ($urandom_range(1, 6)) send_byte(plain_byte());
    end else if (r <= 7) begin
      send_byte(CH_PERCENT);
      repeat ($urandom_range(0, 2)) begin
        send_byte($urandom_range(0, 1) ? CH_ZERO : CH_MINUS);
      end
      // Width digits: usually a few, sometimes enough to overflow.
      nd = $urandom_range(0, 19);
      nd = (nd < 6) ? 0 : (nd < 17) ? $urandom_range(1, 3) : $urandom_range(5, 6);
      repeat (nd) send_byte(digit_byte());
      if ($urandom_range(0, 2) == 0) begin
        send_byte(CH_DOT);
        nd = $urandom_range(0, 19);
        nd = (nd < 5) ? 0 : (nd < 17) ? $urandom_range(1, 3) : $urandom_range(5, 6);
        repeat (nd) send_byte(digit_byte());
      end
      if ($urandom_range(0, 99) < 85) begin
        send_byte(CONV_BYTES[$urandom_range(0, 7)]);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end else if (r == 8) begin
      send_byte(CH_TERM);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Output side: ready stays high through calm stretches and otherwise
  // drops for random stalls, most short and a few long.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Token checker. Port values are read at the edge, before any register
  // of the block updates, so the sampled beat is the one being taken.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_tok = {kind, zero_fill, align_left, uppercase, field_width,
                 has_precision, precision_value, run_offset, run_length,
                 resume_position, last};
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected token: %s", token_text(got_tok));
        end
      end else begin
        want_tok = expected_tokens.pop_front();
        if (got_tok !== want_tok) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("token mismatch\n  want %s\n  got  %s",
                     token_text(want_tok), token_text(got_tok));
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    bit drained_once;
    drained_once = 1'b0;

    // Scripted string. Positions noted below are the byte offsets that the
    // fixed tokens refer to.
    add_row(CH_TERM, 1'b1, fixed_token(K_END, 16'd0, 16'd0, 16'd0));
    add_row(CH_PERCENT);
    add_row(CH_PERCENT, 1'b1, fixed_token(K_PERCENT, 16'd0, 16'd0, 16'd2));
    add_row(8'hFF);                 // one-byte literal at offset 2
    add_row(CH_PERCENT, 1'b1, fixed_token(K_LITERAL, 16'd2, 16'd1, 16'd3));
    add_row(CH_MINUS);              // both flags, width 12, precision 3, 'X'
    add_row(CH_ZERO);
    add_row("1");
    add_row("2");
    add_row(CH_DOT);
    add_row("3");
    add_row(CH_UPPER_X);
    add_row(CH_PERCENT);
    add_row(CH_LOWER_C);
    add_row(CH_PERCENT);
    add_row(CH_LOWER_D);
    add_row(CH_PERCENT);            // unknown conversion, consumed at 16
    add_row("q", 1'b1, fixed_token(K_INVALID, 16'd0, 16'd0, 16'd17));
    add_row(CH_PERCENT);            // directive cut off by the terminator
    add_row("5");
    add_row(CH_TERM);
    add_row("b");                   // literal closed by the terminator
    add_row(CH_TERM);
    add_row(CH_PERCENT);            // width 65536 overflows on its last digit
    add_row("6");
    add_row("5");
    add_row("5");
    add_row("3");
    add_row("6");
    add_row(CH_TERM);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      send_byte(script[i].ch, script[i].fixed, script[i].fixed_tok);
    end

    while (sent_bytes < script.size() + RANDOM_BYTES) begin
      // Switch between stretches with and without idling now and then.
      if ($urandom_range(0, 39) == 0) begin
        no_idle = ~no_idle;
      end
      if (!drained_once && sent_bytes > script.size() + RANDOM_BYTES / 2) begin
        wait_drained();
        drained_once = 1'b1;
      end
      send_random_piece();
    end

    // One longer literal run without idling, then a directive and another
    // literal before terminating.
    no_idle = 1'b1;
    send_byte(CH_TERM);
    repeat (LONG_RUN_BYTES) send_byte(plain_byte());
    send_byte(CH_PERCENT);
    send_byte(CH_LOWER_D);
    send_byte("z");
    no_idle = 1'b0;
    send_byte(CH_TERM);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
